FILE: sv/tpq_pkg.sv
// Shared types and codes for the tag pool request queue.
package tpq_pkg;

  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int TAG_W  = 4;
  localparam int DATA_W = 64;
  localparam int FREE_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH         = 2'd0;
  localparam logic [OP_W-1:0] OP_PEEK         = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE      = 2'd2;
  localparam logic [OP_W-1:0] OP_PEEK_RELEASE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_TAKEN = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

FILE: sv/tpq_tag_fifo.sv
// Tag FIFO with a registered head word, optionally preset to tags 0..TAGS-1.
module tpq_tag_fifo #(
  parameter int TAGS   = 16,
  parameter bit PRESET = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tpq_pkg::fifo_ctl_t        ctl,
  input  logic [$clog2(TAGS)-1:0]   push_tag,
  output logic [$clog2(TAGS)-1:0]   front,
  output logic [$clog2(TAGS+1)-1:0] count
);
  import tpq_pkg::*;

  localparam int TW = $clog2(TAGS);
  localparam int CW = $clog2(TAGS+1);
  localparam logic [TW-1:0] LAST = TW'(TAGS - 1);

  logic [TW-1:0] mem [TAGS];
  logic [TW-1:0] head;
  logic [TW-1:0] tail;
  logic          wrapped;
  logic [TW-1:0] head_next;
  logic [TW-1:0] tail_next;
  logic          unwritten;

  assign head_next = ctl.pop  ? ((head == LAST) ? '0 : head + 1'b1) : head;
  assign tail_next = ctl.push ? ((tail == LAST) ? '0 : tail + 1'b1) : tail;
  // preset entries not yet overwritten read as their own index
  assign unwritten = PRESET && !wrapped && (head_next >= tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      wrapped <= 1'b0;
      count   <= PRESET ? CW'(TAGS) : '0;
      front   <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count + CW'(ctl.push) - CW'(ctl.pop);
      if (ctl.push && tail == LAST) begin
        wrapped <= 1'b1;
      end
      // head word is fetched ahead from the next head pointer; bypass a write to the same slot
      if (ctl.push && tail == head_next) begin
        front <= push_tag;
      end else if (unwritten) begin
        front <= head_next;
      end else begin
        front <= mem[head_next];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= push_tag;
    end
  end

endmodule

FILE: sv/tag_pool_request_queue.sv
// Top level of the tag pool request queue.
//
//   channel  | handshake              | words
//   ---------+------------------------+--------------------------------------------
//   request  | req_valid / req_stall  | opcode, release_tag, payload
//   response | rsp_valid / rsp_stall  | status, tag_out, data_out, pending_empty,
//            |                        | free_tags
//
// One request per cycle while req_stall is low; the response is registered from the
// input register when it advances (result register loaded with the slot data read).
// After reset the free list holds tags 0..TAGS-1 and nothing is pending.
// A stalled response holds; the input register takes one more word behind it.
module tag_pool_request_queue #(
  parameter int TAGS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [tpq_pkg::OP_W-1:0]      opcode,
  input  logic [tpq_pkg::TAG_W-1:0]     release_tag,
  input  logic [tpq_pkg::DATA_W-1:0]    payload,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [tpq_pkg::STAT_W-1:0]    status,
  output logic [tpq_pkg::TAG_W-1:0]     tag_out,
  output logic [tpq_pkg::DATA_W-1:0]    data_out,
  output logic                          pending_empty,
  output logic [tpq_pkg::FREE_W-1:0]    free_tags
);
  import tpq_pkg::*;

  localparam int TW = $clog2(TAGS);
  localparam int CW = $clog2(TAGS+1);
  localparam int NTAKEN = 1 << TAG_W;

  logic              ir_valid;
  logic [OP_W-1:0]   ir_op;
  logic [TAG_W-1:0]  ir_rtag;
  logic [DATA_W-1:0] ir_payload;
  logic              adv;

  fifo_ctl_t         free_ctl;
  fifo_ctl_t         pend_ctl;
  logic [TW-1:0]     free_in;
  logic [TW-1:0]     free_front;
  logic [TW-1:0]     pend_front;
  logic [CW-1:0]     free_count;
  logic [CW-1:0]     pend_count;
  logic [CW-1:0]     free_after;
  logic [CW-1:0]     pend_after;
  logic [CW+FREE_W-1:0] free_wide_cnt;

  logic [TW+TAG_W-1:0] free_wide;
  logic [TW+TAG_W-1:0] pend_wide;
  logic [TW+TAG_W-1:0] rtag_wide;
  logic                pend_small;

  // only tags below 16 can ever be named for release, so only they need a bit
  logic [NTAKEN-1:0] taken;
  logic              set_taken;
  logic              clr_taken;

  logic [DATA_W-1:0] slot [TAGS];
  logic              slot_we;
  logic              data_sel;
  logic [STAT_W-1:0] st;
  logic [TAG_W-1:0]  tag_o;

  assign adv       = ir_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = ir_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!req_stall) begin
      ir_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      ir_op      <= opcode;
      ir_rtag    <= release_tag;
      ir_payload <= payload;
    end
  end

  assign free_wide  = {{TAG_W{1'b0}}, free_front};
  assign pend_wide  = {{TAG_W{1'b0}}, pend_front};
  assign rtag_wide  = {{TW{1'b0}}, ir_rtag};
  assign pend_small = pend_wide < (TW+TAG_W)'(NTAKEN);

  always_comb begin
    free_ctl  = '0;
    pend_ctl  = '0;
    free_in   = rtag_wide[TW-1:0];
    st        = ST_OK;
    tag_o     = '0;
    data_sel  = 1'b0;
    slot_we   = 1'b0;
    set_taken = 1'b0;
    clr_taken = 1'b0;
    case (ir_op) inside
      OP_PUSH: begin
        if (free_count == '0) begin
          st = ST_NO_FREE;
        end else begin
          free_ctl.pop  = adv;
          pend_ctl.push = adv;
          slot_we       = adv;
          tag_o         = free_wide[TAG_W-1:0];
        end
      end
      OP_RELEASE: begin
        // tags at or above TAGS never get a taken bit set
        if (!taken[ir_rtag]) begin
          st = ST_NOT_TAKEN;
        end else begin
          free_ctl.push = adv;
          clr_taken     = adv;
        end
      end
      OP_PEEK, OP_PEEK_RELEASE: begin
        if (pend_count == '0) begin
          st = ST_EMPTY;
        end else begin
          pend_ctl.pop = adv;
          data_sel     = 1'b1;
          tag_o        = pend_wide[TAG_W-1:0];
          if (ir_op == OP_PEEK_RELEASE) begin
            free_ctl.push = adv;
            free_in       = pend_front;
          end else begin
            set_taken = adv && pend_small;
          end
        end
      end
    endcase
  end

  assign free_after    = free_count + CW'(free_ctl.push) - CW'(free_ctl.pop);
  assign pend_after    = pend_count + CW'(pend_ctl.push) - CW'(pend_ctl.pop);
  assign free_wide_cnt = {{FREE_W{1'b0}}, free_after};

  tpq_tag_fifo #(.TAGS(TAGS), .PRESET(1'b1)) u_free (
    .clk      (clk),
    .rst      (rst),
    .ctl      (free_ctl),
    .push_tag (free_in),
    .front    (free_front),
    .count    (free_count)
  );

  tpq_tag_fifo #(.TAGS(TAGS), .PRESET(1'b0)) u_pend (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pend_ctl),
    .push_tag (free_front),
    .front    (pend_front),
    .count    (pend_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else begin
      if (set_taken) begin
        taken[pend_wide[TAG_W-1:0]] <= 1'b1;
      end
      if (clr_taken) begin
        taken[ir_rtag] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // slot store and result word; data is read straight into the output register
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot[free_front] <= ir_payload;
    end
    if (adv) begin
      status        <= st;
      tag_out       <= tag_o;
      data_out      <= data_sel ? slot[pend_front] : '0;
      pending_empty <= (pend_after == '0);
      free_tags     <= free_wide_cnt[FREE_W-1:0];
    end
  end

  a_tag_conserve: assert property (@(posedge clk) disable iff (rst)
    (int'(free_count) + int'(pend_count) + $countones(taken)) <= TAGS)
    else $error("tag accounting exceeds pool size");

  a_push_pending: assert property (@(posedge clk) disable iff (rst)
    adv && pend_ctl.push |=> !pending_empty)
    else $error("push reported empty pending queue");

  a_release_free: assert property (@(posedge clk) disable iff (rst)
    adv && free_ctl.push |=> free_tags != '0)
    else $error("release reported no free tags");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> tag_out == '0 && data_out == '0)
    else $error("error response carries tag or data");

endmodule
